### rtl/ssf_pkg.sv
// Shared types, constants and helpers for the forward substring search block.
`default_nettype none

package ssf_pkg;

    localparam int NEEDLE_BYTES   = 16;
    localparam int NEEDLE_IDX_W   = 4;
    localparam int LEN_REG_W      = 5;
    localparam int OFFSET_W       = 16;
    localparam int RESULT_W       = 16;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_MAX_NEEDLE = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7a;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CASE_DELTA = CHAR_UA - CHAR_LA;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LO  = 3'd0,
        CFG_NEEDLE_HI  = 3'd1,
        CFG_NEEDLE_LEN = 3'd2,
        CFG_CASE_FOLD  = 3'd3,
        CFG_START_OFS  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] haystack_byte;
        logic       first_byte;
        logic       last_byte;
    } t_hay_item;

    typedef struct packed {
        logic                match_found;
        logic [RESULT_W-1:0] result_index;
        logic                length_overflow;
    } t_res_item;

    // needle_len holds the already clamped length
    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][7:0] needle;
        logic [LEN_REG_W-1:0]         needle_len;
        logic                         case_fold;
        logic [OFFSET_W-1:0]          start_offset;
    } t_cfg;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CHAR_LA && c <= CHAR_LZ) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ssf_hay_if.sv
// Haystack byte channel: valid/ready with one byte and its marks.
`default_nettype none

interface ssf_hay_if
    import ssf_pkg::*;
();
    logic      valid;
    logic      ready;
    t_hay_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ssf_res_if.sv
// Search result channel: valid/ready with one result.
`default_nettype none

interface ssf_res_if
    import ssf_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ssf_cfg_regs.sv
// Configuration register file: needle, clamped length, case mode, start offset.
`default_nettype none

module ssf_cfg_regs
    import ssf_pkg::*;
#(
    parameter int MAX_NEEDLE = DEF_MAX_NEEDLE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    localparam int WIN = (MAX_NEEDLE < NEEDLE_BYTES) ? MAX_NEEDLE : NEEDLE_BYTES;
    localparam logic [LEN_REG_W-1:0] LEN_CAP = LEN_REG_W'(WIN);

    t_cfg                 r_cfg;
    logic [LEN_REG_W-1:0] len_raw;
    logic [LEN_REG_W-1:0] len_eff;

    assign len_raw = i_cfg_data[LEN_REG_W-1:0];
    assign len_eff = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NEEDLE_LO: begin
                    r_cfg.needle[NEEDLE_BYTES/2-1:0] <= i_cfg_data;
                end
                CFG_NEEDLE_HI: begin
                    r_cfg.needle[NEEDLE_BYTES-1:NEEDLE_BYTES/2] <= i_cfg_data;
                end
                CFG_NEEDLE_LEN: begin
                    r_cfg.needle_len <= len_eff;
                end
                CFG_CASE_FOLD: begin
                    r_cfg.case_fold <= i_cfg_data[0];
                end
                CFG_START_OFS: begin
                    r_cfg.start_offset <= i_cfg_data[OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.needle_len <= LEN_CAP)
        else $error("stored needle length above window size");

endmodule

`default_nettype wire

### rtl/ssf_search.sv
// Input register, byte window, match compare and per-haystack search state.
`default_nettype none

module ssf_search
    import ssf_pkg::*;
#(
    parameter int MAX_NEEDLE = DEF_MAX_NEEDLE,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_hay_item i_in,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_take_ok,
    output logic           o_res_valid,
    output t_res_item      o_res
);

    localparam int WIN   = (MAX_NEEDLE < NEEDLE_BYTES) ? MAX_NEEDLE : NEEDLE_BYTES;
    localparam int CMP_W = (COUNT_BITS > OFFSET_W) ? COUNT_BITS : OFFSET_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  r_s1_valid;
    t_hay_item             r_s1;
    logic [WIN-1:0][7:0]   r_win;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_sat;
    logic                  r_hit;
    logic [COUNT_BITS-1:0] r_start;

    logic [WIN-1:0][7:0]   n_win;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  n_sat;
    logic                  n_hit;
    logic [COUNT_BITS-1:0] n_start;

    logic                  s1_fire;
    logic [WIN-1:0]        lane_eq;
    logic                  win_match;
    t_res_item             res;

    assign s1_fire    = r_s1_valid && (!r_s1.last_byte || i_take_ok);
    assign o_in_ready = !r_s1_valid || s1_fire;

    // right-aligned needle compare: lane k checks the k-th newest byte against needle byte n-1-k
    always_comb begin
        logic [NEEDLE_IDX_W-1:0] j;
        n_win[0] = r_s1.haystack_byte;
        for (int k = 1; k < WIN; k++) begin
            n_win[k] = r_s1.first_byte ? 8'h00 : r_win[k-1];
        end
        for (int k = 0; k < WIN; k++) begin
            j = NEEDLE_IDX_W'(int'(i_cfg.needle_len) - 1 - k);
            if (LEN_REG_W'(k) < i_cfg.needle_len) begin
                lane_eq[k] = fold_byte(n_win[k], i_cfg.case_fold)
                          == fold_byte(i_cfg.needle[j], i_cfg.case_fold);
            end else begin
                lane_eq[k] = 1'b1;
            end
        end
        win_match = &lane_eq;
    end

    always_comb begin
        logic [COUNT_BITS-1:0] b_cnt;
        logic                  b_sat;
        logic                  b_hit;
        logic [COUNT_BITS-1:0] b_start;
        logic [COUNT_BITS-1:0] s;
        logic [CMP_W-1:0]      cnt_w;
        logic [CMP_W-1:0]      ofs_w;
        logic [CMP_W-1:0]      idx_w;
        logic                  found;

        b_cnt   = r_s1.first_byte ? '0 : r_cnt;
        b_sat   = r_s1.first_byte ? 1'b0 : r_sat;
        b_hit   = r_s1.first_byte ? 1'b0 : r_hit;
        b_start = r_s1.first_byte ? '0 : r_start;

        n_cnt   = b_cnt;
        n_sat   = b_sat;
        n_hit   = b_hit;
        n_start = b_start;
        s       = '0;

        if (!b_sat) begin
            if (b_cnt == CNT_MAX) begin
                n_sat = 1'b1;
            end else begin
                n_cnt = b_cnt + 1'b1;
                s     = n_cnt - COUNT_BITS'(i_cfg.needle_len);
                if (i_cfg.needle_len != '0 && !b_hit
                        && n_cnt >= COUNT_BITS'(i_cfg.needle_len)
                        && CMP_W'(s) >= CMP_W'(i_cfg.start_offset)
                        && win_match) begin
                    n_hit   = 1'b1;
                    n_start = s;
                end
            end
        end

        cnt_w = CMP_W'(n_cnt);
        ofs_w = CMP_W'(i_cfg.start_offset);
        if (i_cfg.needle_len == '0) begin
            found = ofs_w <= cnt_w;
            idx_w = found ? ofs_w : cnt_w;
        end else begin
            found = n_hit;
            idx_w = found ? CMP_W'(n_start) : cnt_w;
        end
        res.match_found     = found;
        res.result_index    = idx_w[RESULT_W-1:0];
        res.length_overflow = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt      <= '0;
            r_sat      <= 1'b0;
            r_hit      <= 1'b0;
            r_start    <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                if (r_s1.last_byte) begin
                    r_cnt   <= '0;
                    r_sat   <= 1'b0;
                    r_hit   <= 1'b0;
                    r_start <= '0;
                end else begin
                    r_cnt   <= n_cnt;
                    r_sat   <= n_sat;
                    r_hit   <= n_hit;
                    r_start <= n_start;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
        if (s1_fire) begin
            r_win <= n_win;
        end
    end

    assign o_res_valid = s1_fire && r_s1.last_byte;
    assign o_res       = res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_cnt == CNT_MAX))
        else $error("saturation flag set below full count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_start < r_cnt))
        else $error("hit start not behind byte count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stalled input register lost its item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_take_ok)
        else $error("result issued while output register full");

endmodule

`default_nettype wire

### rtl/ssf_out_reg.sv
// Result register between the search logic and the result channel.
`default_nettype none

module ssf_out_reg
    import ssf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_res_item i_item,
    output logic           o_take_ok,
    output logic           o_valid,
    output t_res_item      o_item,
    input  wire logic      i_ready
);

    logic      r_valid;
    t_res_item r_item;

    assign o_take_ok = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/substring_search_forward_core.sv
// Forward substring search core: top level.
//
// Haystack bytes arrive on i_hay (valid/ready), each with first and last marks.
// The needle, its length, case-fold mode and start offset are set through the
// write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
// One result transaction leaves on o_res for every byte marked last: the
// earliest match start at or after the start offset, or the haystack length.
// Throughput: one byte per cycle while no last byte waits on a full result register;
// the window compare is combinational between the input register and the result register.
// A last byte passes the input register, then its result the output register, which drives o_res.valid.
// A stalled receiver holds the result in the output register; further
// non-last bytes still flow, and a second last byte waits in the input
// register until the pending result is taken.
// Reset clears the configuration, the search state and both valid flags;
// after each result the search state is cleared, so the next byte starts a
// new haystack even without a first mark.
`default_nettype none

module substring_search_forward_core
    import ssf_pkg::*;
#(
    parameter int MAX_NEEDLE = DEF_MAX_NEEDLE,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ssf_hay_if.sink                    i_hay,
    ssf_res_if.source                  o_res
);

    t_cfg      cfg;
    logic      take_ok;
    logic      res_valid;
    t_res_item res;

    ssf_cfg_regs #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ssf_search #(
        .MAX_NEEDLE (MAX_NEEDLE),
        .COUNT_BITS (COUNT_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_hay.valid),
        .o_in_ready  (i_hay.ready),
        .i_in        (i_hay.payload),
        .i_cfg       (cfg),
        .i_take_ok   (take_ok),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ssf_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (res_valid),
        .i_item    (res),
        .o_take_ok (take_ok),
        .o_valid   (o_res.valid),
        .o_item    (o_res.payload),
        .i_ready   (o_res.ready)
    );

endmodule

`default_nettype wire

### tb/ssf_search_checker.sv
// Checker for the substring search core: mirrors the registers, predicts results, compares.
`timescale 1ns / 1ps

module ssf_search_checker
    import ssf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ssf_hay_if                         i_hay,
    ssf_res_if                         i_res,
    input  wire logic                  i_end,
    output int                         o_fail_count
);

    localparam int unsigned COUNT_MAX = (1 << DEF_COUNT_BITS) - 1;

    logic [CFG_DATA_W-1:0] needle_lo;
    logic [CFG_DATA_W-1:0] needle_hi;
    logic [LEN_REG_W-1:0]  needle_len;
    logic                  fold_en;
    logic [OFFSET_W-1:0]   start_ofs;

    logic [7:0]  recent [DEF_MAX_NEEDLE];
    int unsigned seen_count;
    bit          saturated;
    bit          hit_seen;
    int unsigned hit_at;
    t_res_item   expected_results[$];
    bit          end_reported;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (fold_en && c >= CHAR_LA && c <= CHAR_LZ) begin
            return c - CHAR_LA + CHAR_UA;
        end
        return c;
    endfunction

    function automatic bit window_hit(input int n);
        logic [2*CFG_DATA_W-1:0] both;
        both = {needle_hi, needle_lo};
        for (int j = 0; j < n; j++) begin
            if (upcase(recent[n-1-j]) != upcase(both[8*j +: 8])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void clear_search();
        foreach (recent[k]) recent[k] = '0;
        seen_count = 0;
        saturated  = 1'b0;
        hit_seen   = 1'b0;
        hit_at     = 0;
    endfunction

    function automatic void track_byte(input t_hay_item it);
        int        n;
        t_res_item r;
        n = (needle_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len);
        if (it.first_byte) begin
            clear_search();
        end
        for (int k = DEF_MAX_NEEDLE - 1; k > 0; k--) begin
            recent[k] = recent[k-1];
        end
        recent[0] = it.haystack_byte;
        if (!saturated) begin
            if (seen_count == COUNT_MAX) begin
                saturated = 1'b1;
            end else begin
                seen_count++;
                if (n > 0 && !hit_seen && seen_count >= n &&
                    seen_count - n >= start_ofs && window_hit(n)) begin
                    hit_seen = 1'b1;
                    hit_at   = seen_count - n;
                end
            end
        end
        if (it.last_byte) begin
            if (n == 0) begin
                r.match_found  = (start_ofs <= seen_count);
                r.result_index = r.match_found ? start_ofs : RESULT_W'(seen_count);
            end else begin
                r.match_found  = hit_seen;
                r.result_index = hit_seen ? RESULT_W'(hit_at) : RESULT_W'(seen_count);
            end
            r.length_overflow = saturated;
            expected_results.push_back(r);
            clear_search();
        end
    endfunction

    always @(posedge i_clk) begin
        t_res_item want;
        t_res_item got;
        if (!i_rst_n) begin
            needle_lo    = '0;
            needle_hi    = '0;
            needle_len   = '0;
            fold_en      = 1'b0;
            start_ofs    = '0;
            o_fail_count = 0;
            end_reported = 1'b0;
            expected_results.delete();
            clear_search();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NEEDLE_LO:  needle_lo  = i_cfg_data;
                    CFG_NEEDLE_HI:  needle_hi  = i_cfg_data;
                    CFG_NEEDLE_LEN: needle_len = i_cfg_data[LEN_REG_W-1:0];
                    CFG_CASE_FOLD:  fold_en    = i_cfg_data[0];
                    CFG_START_OFS:  start_ofs  = i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: %p", got);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.match_found !== want.match_found) begin
                        $error("match_found: expected %0d, got %0d",
                               want.match_found, got.match_found);
                        o_fail_count++;
                    end
                    if (got.result_index !== want.result_index) begin
                        $error("result_index: expected %0d, got %0d",
                               want.result_index, got.result_index);
                        o_fail_count++;
                    end
                    if (got.length_overflow !== want.length_overflow) begin
                        $error("length_overflow: expected %0d, got %0d",
                               want.length_overflow, got.length_overflow);
                        o_fail_count++;
                    end
                end
            end
            if (i_hay.valid && i_hay.ready) begin
                track_byte(i_hay.payload);
            end
            if (i_end && !end_reported) begin
                end_reported = 1'b1;
                if (expected_results.size() != 0) begin
                    $error("%0d expected result(s) never arrived", expected_results.size());
                    o_fail_count++;
                end
            end
        end
    end

endmodule

### tb/substring_search_forward_core_tb.sv
// Top of the substring search testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module substring_search_forward_core_tb;
    import ssf_pkg::*;

    localparam int         IDLE_MAX      = 13;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_BYTES  = 450;
    localparam logic [7:0] CASE_BIT      = CHAR_LA - CHAR_UA;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_START_OFS + 1);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  drained;
    int                    fail_count;

    int         lasts_sent;
    int         results_taken;
    int         random_bytes_sent;
    bit         tx_calm;
    bit         rx_calm;
    logic [7:0] pattern [NEEDLE_BYTES];
    int         pattern_len;

    ssf_hay_if hay_ch ();
    ssf_res_if res_ch ();

    substring_search_forward_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_hay      (hay_ch),
        .o_res      (res_ch)
    );

    ssf_search_checker search_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_hay        (hay_ch),
        .i_res        (res_ch),
        .i_end        (drained),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #20_000_000;
        $display("Timeout waiting for the search core");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int idle_draw(input bit calm);
        return calm ? 0 : int'($urandom_range(0, IDLE_MAX));
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0, 1:    return CHAR_LA + 8'($urandom_range(0, 2));
            2, 3:    return CHAR_UA + 8'($urandom_range(0, 2));
            4:       return $urandom_range(0, 1) ? CHAR_LZ : CHAR_LZ + 8'd1;
            5:       return $urandom_range(0, 1) ? CHAR_LA - 8'd1 : CHAR_UA - 8'd1;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] text_word(input string s);
        logic [CFG_DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    // result sink: stall drawn per transaction, ready held high through bursts
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_draw(rx_calm);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            results_taken++;
            if ($urandom_range(0, 15) == 0) begin
                rx_calm = !rx_calm;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        gap = idle_draw(tx_calm);
        if (gap > 0) begin
            hay_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hay_ch.valid   <= 1'b1;
        hay_ch.payload <= '{haystack_byte: b, first_byte: f, last_byte: l};
        do @(posedge i_clk); while (!hay_ch.ready);
        if (l) begin
            lasts_sent++;
        end
    endtask

    task automatic send_text(input string s, input bit mark_first);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], mark_first && i == 0, i == s.len() - 1);
        end
    endtask

    task automatic send_random_hay(input int len, input bit mark_first, input bit stray);
        int         pos;
        int         stray_at;
        logic [7:0] b;
        logic [7:0] lower;
        pos = -1;
        if (pattern_len > 0 && len >= pattern_len && $urandom_range(0, 2) != 0) begin
            pos = $urandom_range(0, len - pattern_len);
        end
        stray_at = stray ? int'($urandom_range(1, len)) : len;
        for (int i = 0; i < len; i++) begin
            if (pos >= 0 && i >= pos && i < pos + pattern_len) begin
                b     = pattern[i - pos];
                lower = b | CASE_BIT;
                if (lower >= CHAR_LA && lower <= CHAR_LZ && $urandom_range(0, 1)) begin
                    b = b ^ CASE_BIT;
                end
            end else begin
                b = pick_byte();
            end
            send_byte(b, (i == 0 && mark_first) || i == stray_at, i == len - 1);
        end
    endtask

    // pause until every result is back and the pipeline has settled
    task automatic drain();
        hay_ch.valid <= 1'b0;
        while (results_taken < lasts_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [LEN_REG_W-1:0] len, input logic fold,
                             input logic [OFFSET_W-1:0] ofs, input bit noisy);
        logic [CFG_DATA_W-1:0]   junk;
        logic [2*CFG_DATA_W-1:0] both;
        logic [CFG_IDX_W-1:0]    idx_q[$];
        logic [CFG_DATA_W-1:0]   data_q[$];
        junk   = noisy ? {$urandom(), $urandom()} : '0;
        idx_q  = '{CFG_NEEDLE_LO, CFG_NEEDLE_HI, CFG_NEEDLE_LEN, CFG_CASE_FOLD, CFG_START_OFS};
        data_q = '{lo, hi, {junk[CFG_DATA_W-1:LEN_REG_W], len}, {junk[CFG_DATA_W-1:1], fold},
                   {junk[CFG_DATA_W-1:OFFSET_W], ofs}};
        if (noisy) begin
            idx_q.push_back(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(0,
                            (1 << CFG_IDX_W) - 1 - CFG_IDX_SPARE)));
            data_q.push_back({$urandom(), $urandom()});
        end
        foreach (idx_q[k]) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_q[k];
            cfg_data <= data_q[k];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        both = {hi, lo};
        pattern_len = (len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(len);
        for (int j = 0; j < NEEDLE_BYTES; j++) begin
            pattern[j] = both[8*j +: 8];
        end
    endtask

    task automatic random_phase();
        logic [2*CFG_DATA_W-1:0] both;
        logic [LEN_REG_W-1:0]    len;
        logic [OFFSET_W-1:0]     ofs;
        int                      eff;
        int                      hays;
        int                      hay_len;
        case ($urandom_range(0, 9))
            0:          len = '0;
            7, 8:       len = LEN_REG_W'($urandom_range(5, NEEDLE_BYTES));
            9:          len = LEN_REG_W'($urandom_range(NEEDLE_BYTES + 1, (1 << LEN_REG_W) - 1));
            default:    len = LEN_REG_W'($urandom_range(1, 4));
        endcase
        eff = (len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(len);
        for (int j = 0; j < NEEDLE_BYTES; j++) begin
            both[8*j +: 8] = (j < eff) ? pick_byte() : 8'($urandom());
        end
        case ($urandom_range(0, 15))
            0:       ofs = '1;
            1, 2:    ofs = OFFSET_W'($urandom());
            default: ofs = OFFSET_W'($urandom_range(0, 12));
        endcase
        configure(both[CFG_DATA_W-1:0], both[2*CFG_DATA_W-1:CFG_DATA_W], len,
                  1'($urandom_range(0, 1)), ofs, $urandom_range(0, 3) == 0);
        tx_calm = ($urandom_range(0, 4) == 0);
        hays = $urandom_range(3, 8);
        for (int h = 0; h < hays; h++) begin
            hay_len = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(1, 24));
            send_random_hay(hay_len, $urandom_range(0, 7) != 0, $urandom_range(0, 9) == 0);
            random_bytes_sent += hay_len;
        end
        drain();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_NEEDLE_LO;
        cfg_data       <= '0;
        hay_ch.valid   <= 1'b0;
        hay_ch.payload <= '0;
        drained        <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset values: empty needle, one-byte haystack
        send_text("q", 1'b1);
        drain();

        configure(text_word("ab"), '0, LEN_REG_W'(2), 1'b0, '0, 1'b0);
        send_text("xab", 1'b1);
        send_text("xAB", 1'b0);
        drain();

        configure(text_word("ab"), '0, LEN_REG_W'(2), 1'b1, OFFSET_W'(2), 1'b0);
        send_text("AbaB", 1'b1);
        drain();

        configure('0, '0, '0, 1'b0, '1, 1'b0);
        send_text("ab", 1'b1);
        drain();

        // full-width needle, oversized length register
        configure('1, {4{16'h00FF}}, '1, 1'b1, '0, 1'b0);
        for (int j = 0; j < NEEDLE_BYTES; j++) begin
            send_byte(pattern[j], j == 0, j == NEEDLE_BYTES - 1);
        end
        drain();

        while (random_bytes_sent < RANDOM_BYTES) begin
            random_phase();
        end

        drain();
        drained <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### substring_search_forward_core.f
rtl/ssf_pkg.sv
rtl/ssf_hay_if.sv
rtl/ssf_res_if.sv
rtl/ssf_cfg_regs.sv
rtl/ssf_search.sv
rtl/ssf_out_reg.sv
rtl/substring_search_forward_core.sv
tb/ssf_search_checker.sv
tb/substring_search_forward_core_tb.sv
